// ===== rtl/core/tiny_harvard_cpu_core_defines.svh =====
// Assertion macros for the tiny Harvard core checker.
// No dependencies.
`ifndef TINY_HARVARD_CPU_CORE_DEFINES_SVH
`define TINY_HARVARD_CPU_CORE_DEFINES_SVH

// same-cycle implication
`define THC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define THC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/thc_pkg.sv =====
// Package for the tiny Harvard core: sizes, opcodes, item kinds, sequencer states.
// No dependencies.
package thc_pkg;

    // store depth, power of two
    localparam int MEM_DEPTH = 256;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int RF_DEPTH  = 16;
    localparam int RF_AW     = $clog2(RF_DEPTH);
    localparam int WORD_W    = 32;
    localparam int TARGET_W  = 28;

    localparam logic [TARGET_W-1:0] HALT_RESET = TARGET_W'(100);

    localparam int S_TUSER_W = 2;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 72;
    localparam int M_HALT_BIT  = 32;
    localparam int M_ERROR_BIT = 33;
    localparam int M_RDVAL_LSB = 34;

    typedef enum logic [1:0] {
        OP_EXEC   = 2'd0,
        OP_PWRITE = 2'd1,
        OP_DWRITE = 2'd2,
        OP_DREAD  = 2'd3
    } thc_op_t;

    typedef enum logic [3:0] {
        OPC_ADD = 4'h0,
        OPC_LW  = 4'h2,
        OPC_SW  = 4'h3,
        OPC_BEQ = 4'h4,
        OPC_J   = 4'hE
    } thc_opc_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_REG1,
        S_REG2,
        S_MEM,
        S_DONE,
        S_CLEAR
    } thc_state_t;

endpackage

// ===== rtl/core/thc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module thc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/tiny_harvard_cpu_core.sv =====
// Store writes, reads and execute while halted or past program memory go from accept straight
// to the result register; J and unknown opcodes pass through fetch first, and ADD, LW, SW and
// BEQ through fetch and the steps below. One transaction in flight: the next is accepted the
// cycle after the result is registered, and registering waits on any output stall. Steps: fetch,
// then two reads through the one register file read port (or one read and the data load).
// Reset (async, rst_n low) clears pc, flags, halt address (to 100); a clearing pass then zeroes all stores.
module tiny_harvard_cpu_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [thc_pkg::S_TDATA_W-1:0] s_tdata,  // address[7:0], write_value[39:8]
    input  logic [thc_pkg::S_TUSER_W-1:0] s_tuser,  // operation[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [thc_pkg::M_TDATA_W-1:0] m_tdata,  // program_counter_out[31:0], halted[32],
                                                    // error[33], read_value[65:34], zero pad
    input  logic                          cfg_wr_en,
    input  logic [thc_pkg::TARGET_W-1:0]  cfg_wr_data
);

    import thc_pkg::*;

    thc_state_t state_reg, state_next;
    thc_op_t    op_reg, op_next;
    thc_op_t    s_op;

    logic [WORD_W-1:0]   pc_reg, pc_next;
    logic                stopped_reg, stopped_next;
    logic                fault_reg, fault_next;
    logic [TARGET_W-1:0] halt_reg;
    logic [WORD_W-1:0]   instr_reg, instr_next;
    logic [WORD_W-1:0]   rs_val_reg, rs_val_next;
    logic [MEM_AW-1:0]   clr_idx_reg, clr_idx_next;

    logic                out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]   out_pc_reg, out_rdval_reg;
    logic                out_halted_reg, out_error_reg;
    logic                out_load;

    logic                 prog_we, prog_re;
    logic [MEM_AW-1:0]    prog_waddr, prog_raddr;
    logic [WORD_W-1:0]    prog_wdata, prog_rdata;
    logic                 data_we, data_re;
    logic [MEM_AW-1:0]    data_waddr, data_raddr;
    logic [WORD_W-1:0]    data_wdata, data_rdata;
    logic                 rf_we, rf_re;
    logic [RF_AW-1:0]     rf_waddr, rf_raddr;
    logic [WORD_W-1:0]    rf_wdata, rf_rdata;

    logic [MEM_AW-1:0]    in_addr;
    logic [WORD_W-1:0]    in_value;
    logic [WORD_W-1:0]    fetched, rf_val, data_val;
    logic [WORD_W-1:0]    imm, pc_inc, pc_tgt, pc_branch;
    thc_opc_t             fetch_opc, cur_opc;

    function automatic logic pc_oob(input logic [WORD_W-1:0] pc);
        return |pc[WORD_W-1:MEM_AW];
    endfunction

    assign s_op     = thc_op_t'(s_tuser);
    assign in_addr  = MEM_AW'(s_tdata[7:0]);
    assign in_value = s_tdata[39:8];

    assign fetched   = prog_rdata;
    assign rf_val    = rf_rdata;
    assign data_val  = data_rdata;
    assign fetch_opc = thc_opc_t'(fetched[31:28]);
    assign cur_opc   = thc_opc_t'(instr_reg[31:28]);
    assign imm       = {{12{instr_reg[19]}}, instr_reg[19:0]};
    assign pc_inc    = pc_reg + WORD_W'(1);
    assign pc_tgt    = {{(WORD_W-TARGET_W){1'b0}}, fetched[TARGET_W-1:0]};

    assign s_tready = (state_reg == S_IDLE);

    thc_ram #(.WIDTH(WORD_W), .DEPTH(MEM_DEPTH)) u_prog_ram
    (
        .clk   (clk),
        .we    (prog_we),
        .waddr (prog_waddr),
        .wdata (prog_wdata),
        .re    (prog_re),
        .raddr (prog_raddr),
        .rdata (prog_rdata)
    );

    thc_ram #(.WIDTH(WORD_W), .DEPTH(MEM_DEPTH)) u_data_ram
    (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .re    (data_re),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    thc_ram #(.WIDTH(WORD_W), .DEPTH(RF_DEPTH)) u_rf_ram
    (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (rf_re),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        pc_next      = pc_reg;
        stopped_next = stopped_reg;
        fault_next   = fault_reg;
        instr_next   = instr_reg;
        rs_val_next  = rs_val_reg;
        clr_idx_next = clr_idx_reg;
        out_load     = 1'b0;
        pc_branch    = pc_inc;

        prog_we    = 1'b0;
        prog_re    = 1'b0;
        prog_waddr = in_addr;
        prog_wdata = in_value;
        prog_raddr = pc_reg[MEM_AW-1:0];
        data_we    = 1'b0;
        data_re    = 1'b0;
        data_waddr = in_addr;
        data_wdata = in_value;
        data_raddr = in_addr;
        rf_we      = 1'b0;
        rf_re      = 1'b0;
        rf_waddr   = instr_reg[27:24];
        rf_wdata   = rs_val_reg + rf_val;
        rf_raddr   = fetched[23:20];

        case (state_reg)
            S_CLEAR:
            begin
                prog_we      = 1'b1;
                prog_waddr   = clr_idx_reg;
                prog_wdata   = '0;
                data_we      = 1'b1;
                data_waddr   = clr_idx_reg;
                data_wdata   = '0;
                rf_we        = 1'b1;
                rf_waddr     = clr_idx_reg[RF_AW-1:0];
                rf_wdata     = '0;
                clr_idx_next = clr_idx_reg + MEM_AW'(1);
                if (clr_idx_reg == MEM_AW'(MEM_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_op;
                    state_next = S_DONE;
                    case (s_op)
                        OP_EXEC:
                        begin
                            if (!stopped_reg)
                            begin
                                if (pc_oob(pc_reg))
                                begin
                                    stopped_next = 1'b1;
                                end
                                else
                                begin
                                    prog_re    = 1'b1;
                                    state_next = S_FETCH;
                                end
                            end
                        end
                        OP_PWRITE: prog_we = 1'b1;
                        OP_DWRITE: data_we = 1'b1;
                        OP_DREAD:  data_re = 1'b1;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_FETCH:
            begin
                instr_next = fetched;
                rf_re      = 1'b1;
                state_next = S_DONE;
                case (fetch_opc)
                    OPC_ADD, OPC_LW, OPC_SW, OPC_BEQ:
                    begin
                        state_next = S_REG1;
                    end
                    OPC_J:
                    begin
                        pc_next      = pc_tgt;
                        stopped_next = (fetched[TARGET_W-1:0] == halt_reg) || pc_oob(pc_tgt);
                    end
                    default:
                    begin
                        pc_next      = pc_inc;
                        stopped_next = 1'b1;
                        fault_next   = 1'b1;
                    end
                endcase
            end
            S_REG1:
            begin
                rs_val_next = rf_val;
                if (cur_opc == OPC_LW)
                begin
                    data_re    = 1'b1;
                    data_raddr = MEM_AW'(rf_val + imm);
                    state_next = S_MEM;
                end
                else
                begin
                    rf_re      = 1'b1;
                    rf_raddr   = (cur_opc == OPC_ADD) ? instr_reg[19:16] : instr_reg[27:24];
                    state_next = S_REG2;
                end
            end
            S_REG2:
            begin
                case (cur_opc)
                    OPC_ADD:
                    begin
                        rf_we = 1'b1;
                    end
                    OPC_SW:
                    begin
                        data_we    = 1'b1;
                        data_waddr = MEM_AW'(rs_val_reg + imm);
                        data_wdata = rf_val;
                    end
                    OPC_BEQ:
                    begin
                        if (rf_val == rs_val_reg)
                        begin
                            pc_branch = pc_reg + imm;
                        end
                    end
                    default:
                    begin
                        pc_branch = pc_inc;
                    end
                endcase
                pc_next      = pc_branch;
                stopped_next = pc_oob(pc_branch);
                state_next   = S_DONE;
            end
            S_MEM:
            begin
                rf_we        = 1'b1;
                rf_wdata     = data_val;
                pc_next      = pc_inc;
                stopped_next = pc_oob(pc_inc);
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            op_reg        <= OP_EXEC;
            pc_reg        <= '0;
            stopped_reg   <= 1'b0;
            fault_reg     <= 1'b0;
            halt_reg      <= HALT_RESET;
            out_valid_reg <= 1'b0;
            clr_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            pc_reg        <= pc_next;
            stopped_reg   <= stopped_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
            clr_idx_reg   <= clr_idx_next;
            if (cfg_wr_en)
            begin
                halt_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        instr_reg  <= instr_next;
        rs_val_reg <= rs_val_next;
        if (out_load)
        begin
            out_pc_reg     <= pc_reg;
            out_halted_reg <= stopped_reg;
            out_error_reg  <= fault_reg;
            out_rdval_reg  <= (op_reg == OP_DREAD) ? data_val : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-M_RDVAL_LSB-WORD_W){1'b0}}, out_rdval_reg,
                       out_error_reg, out_halted_reg, out_pc_reg};

endmodule

// ===== rtl/core/thc_checker.sv =====
// Port-level checker for tiny_harvard_cpu_core, bound to the top level.
// Depends on thc_pkg and tiny_harvard_cpu_core_defines.svh.
`include "tiny_harvard_cpu_core_defines.svh"

module thc_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [thc_pkg::M_TDATA_W-1:0] m_tdata
);

    import thc_pkg::*;

    `THC_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `THC_ASSERT_IMP(a_error_halts, clk, rst_n, m_tvalid && m_tdata[M_ERROR_BIT], m_tdata[M_HALT_BIT], "error without halt")
    `THC_ASSERT_NXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready, "transaction accepted while busy")
    `THC_ASSERT_NXT(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[M_TDATA_W-1:M_RDVAL_LSB+WORD_W] == '0, "nonzero pad bits")

endmodule

bind tiny_harvard_cpu_core thc_checker u_thc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
